FILE: rtl/fxq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fxq_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int REM_BITS  = WORD_BITS + 1;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int LAST      = DIV_STEPS + 1;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    typedef enum logic {
        ST_OK       = 1'b0,
        ST_DIV_ZERO = 1'b1
    } status_t;

    typedef struct packed {
        logic [3:0]            op;
        logic [WORD_BITS-1:0]  a;
        logic [WORD_BITS-1:0]  b;
        logic [WORD_BITS-1:0]  res;
        logic                  less;
        logic                  eq;
        logic                  gt;
        logic                  dz;
        logic                  neg;
        logic [WORD_BITS-1:0]  dvs;
        logic [REM_BITS-1:0]   rem;
        logic [NUM_BITS-1:0]   quo;
    } stage_t;

endpackage
`default_nettype wire

FILE: rtl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake              | fields
// in      | in_valid / in_stall    | req_type, operand_a, operand_b
// out     | out_valid / out_stall  | result_raw, a_less, a_equal, a_greater, status
//
// Stages: input register, setup and multiply, then 40 restoring
// divide steps of one quotient bit each, the last feeding the outputs.
// One transaction per cycle is accepted while in_stall is low; the divider chain sets the depth.
// Reset clears all stage valid bits; payload registers are not reset.
// The whole pipeline holds while the last stage is valid and out_stall is high.
module fixed_point_q24_8_alu
    import fxq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         req_type,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      result_raw,
    output logic                    a_less,
    output logic                    a_equal,
    output logic                    a_greater,
    output logic                    status
);

    stage_t                      s_reg  [0:LAST];
    stage_t                      s_next [0:LAST];
    logic   [LAST:0]             valid_reg;
    logic signed [2*WORD_BITS-1:0] prod_reg;
    logic signed [2*WORD_BITS-1:0] prod_next;
    logic                        advance;

    assign advance  = !(valid_reg[LAST] && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        s_next[0]    = '0;
        s_next[0].op = req_type;
        s_next[0].a  = operand_a;
        s_next[0].b  = operand_b;
    end

    always_comb
    begin
        logic signed [WORD_BITS-1:0] a;
        logic signed [WORD_BITS-1:0] b;
        logic signed [NUM_BITS-1:0]  num;
        stage_t                      s;
        a    = s_reg[0].a;
        b    = s_reg[0].b;
        num  = {a, {FRAC_BITS{1'b0}}};
        s    = s_reg[0];
        s.less = a < b;
        s.eq   = a == b;
        s.gt   = a > b;
        s.dz   = (s_reg[0].op == OP_DIV) && (b == '0);
        s.neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        s.dvs  = b[WORD_BITS-1] ? WORD_BITS'(-b) : b;
        s.rem  = '0;
        s.quo  = num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
        unique case (s_reg[0].op)
            OP_ADD:      s.res = a + b;
            OP_SUB:      s.res = a - b;
            OP_MIN:      s.res = (a <= b) ? a : b;
            OP_MAX:      s.res = (a > b) ? a : b;
            OP_INC:      s.res = a + WORD_BITS'(1);
            OP_DEC:      s.res = a - WORD_BITS'(1);
            OP_FROM_INT: s.res = a << FRAC_BITS;
            OP_TO_INT:   s.res = a >>> FRAC_BITS;
            default:     s.res = '0;
        endcase
        s_next[1] = s;
        prod_next = a * b;
    end

    for (genvar i = 2; i <= LAST; i++)
    begin : g_step
        always_comb
        begin
            logic [REM_BITS-1:0] trial;
            logic                qbit;
            stage_t              s;
            s     = s_reg[i-1];
            trial = {s.rem[REM_BITS-2:0], s.quo[NUM_BITS-1]};
            qbit  = trial >= {1'b0, s.dvs};
            s.rem = qbit ? (trial - {1'b0, s.dvs}) : trial;
            s.quo = {s.quo[NUM_BITS-2:0], qbit};
            if (i == 2 && s.op == OP_MUL)
            begin
                s.res = prod_reg[FRAC_BITS +: WORD_BITS];
            end
            s_next[i] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                s_reg[i] <= s_next[i];
            end
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        logic [NUM_BITS-1:0] q;
        stage_t              s;
        s = s_reg[LAST];
        q = s.neg ? NUM_BITS'(-s.quo) : s.quo;
        if (s.op == OP_DIV)
        begin
            result_raw = s.dz ? '0 : q[WORD_BITS-1:0];
        end
        else
        begin
            result_raw = s.res;
        end
        status    = s.dz ? ST_DIV_ZERO : ST_OK;
        a_less    = s.less;
        a_equal   = s.eq;
        a_greater = s.gt;
        out_valid = valid_reg[LAST];
    end

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({a_less, a_equal, a_greater}))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (result_raw == '0 && a_equal == 1'b0 || result_raw == '0))
        else $error("divide by zero with nonzero result");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(valid_reg)))
        else $error("pipeline moved under stall");

endmodule
`default_nettype wire
